@@ hw/rtl/gbn_pkg.sv @@
// shared types and constants of the greedy box suppression block
package gbn_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int POS_W   = 10;
    localparam int POS_MAX = 1023;
    localparam int THR_W   = 8;
    localparam logic [THR_W-1:0] THR_RESET = 8'd128;

    // depth of the queue between front and back
    localparam int QDEPTH  = 2;

    // geometry of one box
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
    } t_box;

    // classified candidate handed from front to back
    typedef struct packed {
        t_box              box;
        logic [AREA_W-1:0] area;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_cand;

    // one entry of the kept-box table
    typedef struct packed {
        t_box              box;
        logic [AREA_W-1:0] area;
    } t_kept;

    // decision handed to the result channel
    typedef struct packed {
        logic             keep;
        logic [POS_W-1:0] pos;
        logic             overflow;
        logic             last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } t_back_state;

endpackage

@@ hw/rtl/gbn_ifs.sv @@
// handshake channels for candidate boxes and keep decisions
interface gbn_box_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [gbn_pkg::COORD_W-1:0]    box_left;
    logic signed [gbn_pkg::COORD_W-1:0]    box_top;
    logic [gbn_pkg::SIZE_W-1:0]            box_width;
    logic [gbn_pkg::SIZE_W-1:0]            box_height;
    logic                                  frame_last;

    modport source (
        output valid, box_left, box_top, box_width, box_height, frame_last,
        input  ready
    );
    modport sink (
        input  valid, box_left, box_top, box_width, box_height, frame_last,
        output ready
    );
endinterface

interface gbn_res_if;
    logic                        valid;
    logic                        ready;
    logic                        keep;
    logic [gbn_pkg::POS_W-1:0]   candidate_number;
    logic                        table_overflow;
    logic                        frame_done;

    modport source (
        output valid, keep, candidate_number, table_overflow, frame_done,
        input  ready
    );
    modport sink (
        input  valid, keep, candidate_number, table_overflow, frame_done,
        output ready
    );
endinterface

@@ hw/rtl/greedy_box_nms.sv @@
// top level of the greedy box suppression block
//
//  channel   dir  handshake        payload
//  i_box     in   valid / ready    box_left, box_top, box_width, box_height, frame_last
//  o_res     out  valid / ready    keep, candidate_number, table_overflow, frame_done
//  i_cfg     in   i_cfg_we         i_cfg_wdata = overlap threshold, Q0.8
//
//  an item's time in the back end is set by the sweep over the kept-box table at one
//  memory read per cycle through a four-stage compare pipeline; the sweep ends early
//  at the first suppressing entry
//  the front end and a two-entry queue take new items while the back end works
//  reset clears control state and loads threshold 128; the table needs no clearing
//  a stalled result waits in the output register while the next item is swept
module greedy_box_nms #(
    parameter int MAX_KEPT       = 64,
    parameter int MAX_CANDIDATES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gbn_pkg::THR_W-1:0]   i_cfg_wdata,
    gbn_box_if.sink                     i_box,
    gbn_res_if.source                   o_res
);

    logic [gbn_pkg::THR_W-1:0]  r_threshold;
    logic                       w_push;
    gbn_pkg::t_cand             w_push_data;
    logic                       w_full;
    logic                       w_pop;
    logic                       w_q_valid;
    gbn_pkg::t_cand             w_q_head;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= gbn_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // front end
    gbn_front #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (i_box),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // queue between front and back
    gbn_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_head      (w_q_head)
    );

    // back end
    gbn_back #(
        .MAX_KEPT (MAX_KEPT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_q_valid   (w_q_valid),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .o_res       (o_res)
    );

endmodule

@@ hw/rtl/gbn_front.sv @@
// front end: accepts candidates, numbers them and computes their area
module gbn_front #(
    parameter int MAX_CANDIDATES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gbn_box_if.sink           i_box,
    input  logic              i_full,
    output logic              o_push,
    output gbn_pkg::t_cand    o_push_data
);

    localparam int SAT = (MAX_CANDIDATES - 1 < gbn_pkg::POS_MAX) ?
                         (MAX_CANDIDATES - 1) : gbn_pkg::POS_MAX;

    logic                        r_valid;
    gbn_pkg::t_cand              r_cand;
    logic [gbn_pkg::POS_W-1:0]   r_pos;
    logic [gbn_pkg::POS_W-1:0]   n_pos;
    logic                        w_accept;
    logic [gbn_pkg::AREA_W-1:0]  w_area;

    // stage frees up when its item moves into the queue
    assign o_push      = r_valid && !i_full;
    assign o_push_data = r_cand;
    assign i_box.ready = !r_valid || !i_full;
    assign w_accept    = i_box.valid && i_box.ready;

    // area of the incoming box
    assign w_area = gbn_pkg::AREA_W'(i_box.box_width) * gbn_pkg::AREA_W'(i_box.box_height);

    // position within the frame, saturating, restarting after the last item
    always_comb begin
        n_pos = r_pos;
        if (i_box.frame_last) begin
            n_pos = '0;
        end else if (r_pos < gbn_pkg::POS_W'(SAT)) begin
            n_pos = r_pos + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                r_pos   <= n_pos;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    // candidate payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cand.box.left   <= i_box.box_left;
            r_cand.box.top    <= i_box.box_top;
            r_cand.box.width  <= i_box.box_width;
            r_cand.box.height <= i_box.box_height;
            r_cand.area       <= w_area;
            r_cand.pos        <= r_pos;
            r_cand.last       <= i_box.frame_last;
        end
    end

endmodule

@@ hw/rtl/gbn_fifo.sv @@
// short queue of classified candidates between front and back
module gbn_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gbn_pkg::t_cand    i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output gbn_pkg::t_cand    o_head
);

    localparam int PW = (gbn_pkg::QDEPTH > 1) ? $clog2(gbn_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(gbn_pkg::QDEPTH + 1);

    gbn_pkg::t_cand  r_mem [gbn_pkg::QDEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_fill;

    assign o_full  = (r_fill == CW'(gbn_pkg::QDEPTH));
    assign o_valid = (r_fill != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(gbn_pkg::QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(gbn_pkg::QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // queue misuse
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

@@ hw/rtl/gbn_back.sv @@
// back end: sweeps the kept-box table, decides keep or drop, updates the table
module gbn_back #(
    parameter int MAX_KEPT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gbn_pkg::THR_W-1:0]   i_threshold,
    input  logic                        i_q_valid,
    input  gbn_pkg::t_cand              i_q_head,
    output logic                        o_pop,
    gbn_res_if.source                   o_res
);

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int EW = gbn_pkg::COORD_W + 1;
    localparam int DW = gbn_pkg::COORD_W + 2;
    localparam int UW = gbn_pkg::AREA_W + 1;
    localparam int PW = UW + gbn_pkg::THR_W;

    // sequencer and table bookkeeping
    gbn_pkg::t_back_state  r_state;
    gbn_pkg::t_back_state  n_state;
    gbn_pkg::t_cand        r_cand;
    logic                  r_keep;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_issue;
    logic [3:0]            r_v;
    logic [3:0]            n_v;
    logic                  w_issue;
    logic                  w_retire;
    logic                  w_hit;
    logic                  w_full;
    logic                  w_store;

    // table memory and sweep pipeline
    gbn_pkg::t_kept               r_mem [MAX_KEPT];
    gbn_pkg::t_kept               r_rd_data;
    logic [gbn_pkg::SIZE_W-1:0]   r_iw;
    logic [gbn_pkg::SIZE_W-1:0]   r_ih;
    logic [gbn_pkg::AREA_W-1:0]   r_karea;
    logic [gbn_pkg::AREA_W-1:0]   r_inter;
    logic [UW-1:0]                r_area_sum;
    logic [PW-1:0]                r_prod;
    logic [PW-1:0]                r_inter_sh;
    logic                         r_uni_nz;

    // output register
    logic             r_out_valid;
    gbn_pkg::t_res    r_res;

    // overlap edges of candidate and table entry
    logic signed [EW-1:0]  w_cl, w_ct, w_cr, w_cb;
    logic signed [EW-1:0]  w_kl, w_kt, w_kr, w_kb;
    logic signed [EW-1:0]  w_l, w_t, w_r, w_b;
    logic signed [DW-1:0]  w_dw, w_dh;
    logic [UW-1:0]         w_uni;

    assign w_full  = (r_count == CW'(MAX_KEPT));
    assign w_hit   = r_v[3] && r_uni_nz && (r_inter_sh > r_prod);
    assign w_store = w_retire && r_keep && !w_full;

    // next state and sequencer controls
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        w_issue  = 1'b0;
        w_retire = 1'b0;
        unique case (r_state)
            gbn_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = gbn_pkg::ST_SWEEP;
                end
            end
            gbn_pkg::ST_SWEEP: begin
                if (w_hit) begin
                    n_state = gbn_pkg::ST_DONE;
                end else if (r_issue == r_count) begin
                    if (r_v == '0) begin
                        n_state = gbn_pkg::ST_DONE;
                    end
                end else begin
                    w_issue = 1'b1;
                end
            end
            gbn_pkg::ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    w_retire = 1'b1;
                    n_state  = gbn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    // pipeline valids only live inside a sweep
    assign n_v = (r_state == gbn_pkg::ST_SWEEP && !w_hit) ? {r_v[2:0], w_issue} : '0;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_issue     <= '0;
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_v <= n_v;
            if (o_pop) begin
                r_issue <= '0;
            end else if (w_issue) begin
                r_issue <= r_issue + 1'b1;
            end
            if (w_retire && r_cand.last) begin
                r_count <= '0;
            end else if (w_store) begin
                r_count <= r_count + 1'b1;
            end
            if (w_retire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working candidate and its verdict
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cand <= i_q_head;
            r_keep <= 1'b1;
        end else if (w_hit) begin
            r_keep <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_retire) begin
            r_res.keep     <= r_keep;
            r_res.pos      <= r_cand.pos;
            r_res.overflow <= r_keep && w_full;
            r_res.last     <= r_cand.last;
        end
    end

    // kept-box table, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[AW-1:0]] <= {r_cand.box, r_cand.area};
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_issue[AW-1:0]];
        end
    end

    // edges at 17 bits
    always_comb begin
        w_cl = {r_cand.box.left[gbn_pkg::COORD_W-1], r_cand.box.left};
        w_ct = {r_cand.box.top[gbn_pkg::COORD_W-1], r_cand.box.top};
        w_cr = w_cl + $signed({2'b00, r_cand.box.width});
        w_cb = w_ct + $signed({2'b00, r_cand.box.height});
        w_kl = {r_rd_data.box.left[gbn_pkg::COORD_W-1], r_rd_data.box.left};
        w_kt = {r_rd_data.box.top[gbn_pkg::COORD_W-1], r_rd_data.box.top};
        w_kr = w_kl + $signed({2'b00, r_rd_data.box.width});
        w_kb = w_kt + $signed({2'b00, r_rd_data.box.height});
        w_l  = (w_cl > w_kl) ? w_cl : w_kl;
        w_t  = (w_ct > w_kt) ? w_ct : w_kt;
        w_r  = (w_cr < w_kr) ? w_cr : w_kr;
        w_b  = (w_cb < w_kb) ? w_cb : w_kb;
        w_dw = {w_r[EW-1], w_r} - {w_l[EW-1], w_l};
        w_dh = {w_b[EW-1], w_b} - {w_t[EW-1], w_t};
    end

    assign w_uni = r_area_sum - {1'b0, r_inter};

    // sweep pipeline: overlap extents, intersection, union product
    always_ff @(posedge i_clk) begin
        // extents clamp to zero when the boxes do not overlap
        r_iw    <= (w_dw[DW-1] || w_dw == '0) ? '0 : w_dw[gbn_pkg::SIZE_W-1:0];
        r_ih    <= (w_dh[DW-1] || w_dh == '0) ? '0 : w_dh[gbn_pkg::SIZE_W-1:0];
        r_karea <= r_rd_data.area;
        // intersection area and summed areas
        r_inter    <= gbn_pkg::AREA_W'(r_iw) * gbn_pkg::AREA_W'(r_ih);
        r_area_sum <= UW'(r_cand.area) + UW'(r_karea);
        // cross-multiplied ratio test operands
        r_prod     <= PW'(i_threshold) * PW'(w_uni);
        r_inter_sh <= {1'b0, r_inter, {gbn_pkg::THR_W{1'b0}}};
        r_uni_nz   <= (w_uni != '0);
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.keep             = r_res.keep;
    assign o_res.candidate_number = r_res.pos;
    assign o_res.table_overflow   = r_res.overflow;
    assign o_res.frame_done       = r_res.last;

    // table never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEPT))
        else $error("kept count beyond table depth");
    // sweep never reads past the filled part of the table
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (r_issue < r_count))
        else $error("table read beyond kept count");
    // overflow only reported on a kept candidate
    a_ovf_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.overflow) |-> r_res.keep)
        else $error("overflow flagged on dropped candidate");
    // a retired item that was stored leaves one more entry
    a_store_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_store && !r_cand.last) |=> (r_count == $past(r_count) + 1'b1))
        else $error("table count not advanced on store");

endmodule

@@ test/greedy_box_nms_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for greedy_box_nms: directed and random boxes, shadow iou suppression
module greedy_box_nms_test;

    localparam int KEPT_DEPTH   = 64;
    localparam int CAND_MAX     = 1024;
    localparam int POS_LIMIT    = (CAND_MAX - 1) < gbn_pkg::POS_MAX ? (CAND_MAX - 1) :
                                  gbn_pkg::POS_MAX;
    localparam int IDLE_PCT     = 12;
    localparam int LIMIT_CYCLES = 800_000;

    // how the boxes of one frame are placed
    typedef enum int {
        LAYOUT_CLUSTER,
        LAYOUT_GRID,
        LAYOUT_WILD,
        LAYOUT_MIXED
    } t_layout;

    // shadow of the kept-box table and the decisions still due from the block
    class suppress_tracker;
        gbn_pkg::t_box             kept_box [KEPT_DEPTH];
        longint                    kept_area[KEPT_DEPTH];
        int unsigned               kept_num;
        int unsigned               next_pos;
        logic [gbn_pkg::THR_W-1:0] thr;
        gbn_pkg::t_res             due[$];
        int unsigned               errors;

        function new();
            kept_num = 0;
            next_pos = 0;
            thr      = gbn_pkg::THR_RESET;
            errors   = 0;
        endfunction

        function void set_threshold(input logic [gbn_pkg::THR_W-1:0] v);
            thr = v;
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        // intersection area of two boxes, zero when they only touch or miss
        function longint overlap_area(input gbn_pkg::t_box a, input gbn_pkg::t_box b);
            longint ax, ay, ar, ab, bx, by, br, bb, lo_x, lo_y, hi_x, hi_y, w, h;
            ax = $signed(a.left);
            ay = $signed(a.top);
            bx = $signed(b.left);
            by = $signed(b.top);
            ar = ax + longint'(a.width);
            ab = ay + longint'(a.height);
            br = bx + longint'(b.width);
            bb = by + longint'(b.height);
            lo_x = ax > bx ? ax : bx;
            lo_y = ay > by ? ay : by;
            hi_x = ar < br ? ar : br;
            hi_y = ab < bb ? ab : bb;
            w = hi_x - lo_x;
            h = hi_y - lo_y;
            if (w <= 0 || h <= 0)
                return 0;
            return w * h;
        endfunction

        // decide one accepted box and queue the decision
        function void take_box(input gbn_pkg::t_box b, input logic last);
            longint        area, inter, uni;
            bit            survive;
            gbn_pkg::t_res d;
            int unsigned   i;
            survive = 1'b1;
            area    = longint'(b.width) * longint'(b.height);
            for (i = 0; i < kept_num; i++) begin
                inter = overlap_area(b, kept_box[i]);
                uni   = area + kept_area[i] - inter;
                if (uni > 0 && inter * 256 > longint'(thr) * uni) begin
                    survive = 1'b0;
                    break;
                end
            end
            d.keep     = survive;
            d.pos      = next_pos[gbn_pkg::POS_W-1:0];
            d.overflow = 1'b0;
            d.last     = last;
            if (survive) begin
                if (kept_num < KEPT_DEPTH) begin
                    kept_box[kept_num]  = b;
                    kept_area[kept_num] = area;
                    kept_num++;
                end else begin
                    d.overflow = 1'b1;
                end
            end
            due.insert(due.size(), d);
            // frame end clears the table, otherwise the position counts up to its cap
            if (last) begin
                kept_num = 0;
                next_pos = 0;
            end else if (next_pos < POS_LIMIT) begin
                next_pos++;
            end
        endfunction

        // compare one decision from the block with the oldest one due
        function void check_decision(input logic keep, input logic [gbn_pkg::POS_W-1:0] num,
                                     input logic ovf, input logic done);
            gbn_pkg::t_res d;
            if (due.size() == 0) begin
                $error("decision with none due: keep %0d candidate_number %0d", keep, num);
                errors++;
                return;
            end
            d = due.pop_front();
            if (keep !== d.keep) begin
                $error("keep: expected %0d, got %0d", d.keep, keep);
                errors++;
            end
            if (num !== d.pos) begin
                $error("candidate_number: expected %0d, got %0d", d.pos, num);
                errors++;
            end
            if (ovf !== d.overflow) begin
                $error("table_overflow: expected %0d, got %0d", d.overflow, ovf);
                errors++;
            end
            if (done !== d.last) begin
                $error("frame_done: expected %0d, got %0d", d.last, done);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [gbn_pkg::THR_W-1:0] i_cfg_wdata;
    bit                        calm;

    gbn_box_if box_ch ();
    gbn_res_if res_ch ();

    suppress_tracker tracker = new();

    greedy_box_nms #(
        .MAX_KEPT       (KEPT_DEPTH),
        .MAX_CANDIDATES (CAND_MAX)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_box       (box_ch),
        .o_res       (res_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("greedy_box_nms_test: done, errors");
        $finish;
    end

    // decision sink with random back-pressure
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                tracker.check_decision(res_ch.keep, res_ch.candidate_number,
                                       res_ch.table_overflow, res_ch.frame_done);
            res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic gbn_pkg::t_box box_at(input int l, input int t, input int w,
                                             input int h);
        gbn_pkg::t_box b;
        b.left   = l[gbn_pkg::COORD_W-1:0];
        b.top    = t[gbn_pkg::COORD_W-1:0];
        b.width  = w[gbn_pkg::SIZE_W-1:0];
        b.height = h[gbn_pkg::SIZE_W-1:0];
        return b;
    endfunction

    // offer one box and hold it until the block takes it
    task automatic send_box(input gbn_pkg::t_box b, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            box_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        box_ch.valid      <= 1'b1;
        box_ch.box_left   <= b.left;
        box_ch.box_top    <= b.top;
        box_ch.box_width  <= b.width;
        box_ch.box_height <= b.height;
        box_ch.frame_last <= last;
        do @(posedge i_clk); while (box_ch.ready !== 1'b1);
        tracker.take_box(b, last);
    endtask

    // stop offering and wait for every due decision
    task automatic drain_decisions();
        box_ch.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    // threshold write while the block is idle
    task automatic load_threshold(input logic [gbn_pkg::THR_W-1:0] v);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_threshold(v);
    endtask

    // one frame of boxes placed after the given layout
    task automatic send_frame(input t_layout style, input int unsigned len,
                              input bit mark_last);
        gbn_pkg::t_box b, prev;
        t_layout       pick;
        int            cx, cy;
        int unsigned   n;
        prev = box_at(0, 0, 64, 64);
        cx   = $urandom;
        cy   = $urandom;
        for (n = 0; n < len; n++) begin
            pick = style;
            if (style == LAYOUT_MIXED)
                pick = t_layout'($urandom_range(0, 3));
            case (pick)
                // heavy overlap around one center
                LAYOUT_CLUSTER: begin
                    b = box_at(cx + $urandom_range(0, 96) - 48, cy + $urandom_range(0, 96) - 48,
                               $urandom_range(48, 192), $urandom_range(48, 192));
                end
                // disjoint cells, fills the table
                LAYOUT_GRID: begin
                    b = box_at(-32768 + (n % 16) * 4096 + $urandom_range(0, 64),
                               -32768 + ((n / 16) % 16) * 4096 + $urandom_range(0, 64),
                               $urandom_range(0, 4000), $urandom_range(0, 4000));
                end
                // any field value, with extremes forced now and then
                LAYOUT_WILD: begin
                    b = box_at($urandom, $urandom, $urandom, $urandom);
                    case ($urandom_range(0, 7))
                        0: b.width  = '0;
                        1: b.height = '0;
                        2: b.width  = '1;
                        3: b.height = '1;
                        default: ;
                    endcase
                end
                // copy of the previous box, sometimes nudged
                default: begin
                    b = prev;
                    if ($urandom_range(0, 1) == 0)
                        b.left = prev.left + gbn_pkg::COORD_W'($urandom_range(0, 8));
                end
            endcase
            send_box(b, mark_last && (n == len - 1));
            prev = b;
        end
    endtask

    // random frames until the given number of boxes has gone in
    task automatic send_random(input int unsigned total);
        int unsigned sent, len;
        t_layout     style;
        bit          cut;
        sent = 0;
        while (sent < total) begin
            style = t_layout'($urandom_range(0, 3));
            len   = (style == LAYOUT_GRID) ? $urandom_range(50, 90) : $urandom_range(1, 30);
            cut   = len > total - sent;
            if (cut)
                len = total - sent;
            send_frame(style, len, !cut && ($urandom_range(0, 5) != 0));
            sent += len;
        end
    endtask

    // main sequence
    initial begin
        logic [gbn_pkg::THR_W-1:0] corner_thr[3];
        int                        p;
        corner_thr[0] = 8'd255;
        corner_thr[1] = 8'd1;
        corner_thr[2] = 8'd0;

        calm              = 1'b0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= gbn_pkg::THR_RESET;
        box_ch.valid      <= 1'b0;
        box_ch.box_left   <= '0;
        box_ch.box_top    <= '0;
        box_ch.box_width  <= '0;
        box_ch.box_height <= '0;
        box_ch.frame_last <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed boxes at the reset threshold
        send_box(box_at(0, 0, 0, 0), 1'b0);                          // empty table, zero area
        send_box(box_at(0, 0, 0, 0), 1'b0);                          // empty union
        send_box(box_at(-32768, -32768, 32767, 32767), 1'b0);        // most negative corner
        send_box(box_at(-32768, -32768, 32767, 32767), 1'b0);        // exact duplicate
        send_box(box_at(32767, 32767, 32767, 32767), 1'b0);          // widest far edge
        send_box(box_at(0, 0, 160, 160), 1'b0);
        send_box(box_at(80, 0, 160, 160), 1'b0);                     // one third overlap
        send_box(box_at(0, 0, 160, 159), 1'b0);                      // near duplicate
        send_box(box_at(10, 10, 0, 50), 1'b0);                       // zero width inside
        send_box(box_at(0, 0, 160, 80), 1'b0);                       // iou exactly one half
        send_box(box_at(0, 0, 160, 81), 1'b0);                       // just over one half
        send_box(box_at(-1, -1, 1, 1), 1'b0);                        // touching corner
        send_box(box_at(-32768, 32767, 32767, 0), 1'b0);
        send_box(box_at(32767, -32768, 0, 32767), 1'b0);
        send_box(box_at(-16, -16, 32, 32), 1'b0);
        send_box(box_at(0, 0, 160, 160), 1'b1);                      // dropped frame end
        send_box(box_at(-32768, -32768, 32767, 32767), 1'b0);        // table was cleared
        send_box(box_at(-32768, -32768, 32767, 32767), 1'b1);
        drain_decisions();

        // random phases across the threshold range, first one with no idling
        for (p = 0; p < 6; p++) begin
            calm = (p == 0);
            load_threshold(p < 3 ? corner_thr[p] : gbn_pkg::THR_W'($urandom_range(1, 254)));
            send_random(110);
            drain_decisions();
        end
        calm = 1'b0;

        // one long frame: full table and saturating position
        load_threshold(gbn_pkg::THR_W'($urandom_range(64, 200)));
        send_frame(LAYOUT_MIXED, 1028, 1'b1);
        drain_decisions();

        repeat (KEPT_DEPTH + 16) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("greedy_box_nms_test: done, clean");
        else
            $display("greedy_box_nms_test: done, errors");
        $finish;
    end

endmodule
